/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define ASSERT_NOW(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Condition c must hold in the cycle after a.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

/* hdl/kvst_pkg.sv */
`default_nettype none
package kvst_pkg;

	localparam int WORD_W          = 64;
	localparam int FUNC_W          = 2;
	localparam int ENTRIES_DEF     = 128;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int VALUE_BYTES_DEF = 8;

	localparam logic [FUNC_W-1:0] FUNC_GET = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic zero_key;
		logic hit;
		logic last;
	} sts_t;

endpackage
`default_nettype wire

/* hdl/kvst_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"
module kvst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  kvst_pkg::sts_t     sts,
	output kvst_pkg::cmd_t     cmd,
	output logic               busy
);
	import kvst_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = sts.zero_key ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_scan_ends_in_done, clk, arst_n, state_q == S_SCAN && (sts.hit || sts.last), state_q == S_DONE)
	`ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, state_q == S_IDLE && start, busy)
	`ASSERT_NOW(a_clear_blocks_load, clk, arst_n, state_q == S_CLEAR, !cmd.load && !cmd.finish)

endmodule
`default_nettype wire

/* hdl/kvst_dp.sv */
`default_nettype none
`include "assert_macros.svh"
module kvst_dp #(
	parameter int ENTRIES     = kvst_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES   = kvst_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES = kvst_pkg::VALUE_BYTES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  kvst_pkg::cmd_t                  cmd,
	output kvst_pkg::sts_t                  sts,
	input  wire logic [kvst_pkg::FUNC_W-1:0] func,
	input  wire logic [kvst_pkg::WORD_W-1:0] key,
	input  wire logic [kvst_pkg::WORD_W-1:0] value_in,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [kvst_pkg::WORD_W-1:0]     value_out
);
	import kvst_pkg::*;

	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int VAL_W = 8 * VALUE_BYTES;
	localparam int AW    = $clog2(ENTRIES);
	localparam int CW    = AW + 1;

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];

	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic              inv_q;

	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     addr;
	logic              issue;

	logic              vld_s1;
	logic [AW-1:0]     addr_s1;
	logic [KEY_W-1:0]  key_rd_s1;
	logic [VAL_W-1:0]  val_rd_s1;
	logic              match;

	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	logic [VAL_W-1:0]  hit_val_q;
	logic              free_q;
	logic [AW-1:0]     free_idx_q;

	logic              we;
	logic [AW-1:0]     wa;
	logic [KEY_W-1:0]  wk;
	logic [VAL_W-1:0]  wv;
	status_t           st;
	logic [VAL_W-1:0]  vout;

	logic              done_q;
	status_t           status_q;
	logic [WORD_W-1:0] value_out_q;

	assign addr  = cnt_q[AW-1:0];
	assign issue = cmd.scan && (cnt_q < CW'(ENTRIES));
	assign match = vld_s1 && (key_rd_s1 == key_q);

	assign sts.clr_last = (cnt_q == CW'(ENTRIES - 1));
	assign sts.zero_key = (key[KEY_W-1:0] == '0);
	assign sts.hit      = cmd.scan && match;
	assign sts.last     = vld_s1 && (addr_s1 == AW'(ENTRIES - 1));

	// Request registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= key[KEY_W-1:0];
			val_q  <= value_in[VAL_W-1:0];
			inv_q  <= (key[KEY_W-1:0] == '0);
		end
	end

	// Slot counter for both the clearing sweep and the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.clear || issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		if (issue) begin
			key_rd_s1 <= key_mem[addr];
			val_rd_s1 <= val_mem[addr];
		end
		if (we) begin
			key_mem[wa] <= wk;
			val_mem[wa] <= wv;
		end
	end

	// Match and first-free tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.scan && vld_s1) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (key_rd_s1 == '0) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && match) begin
			hit_idx_q <= addr_s1;
			hit_val_q <= val_rd_s1;
		end
		if (cmd.scan && vld_s1 && key_rd_s1 == '0 && !free_q) begin
			free_idx_q <= addr_s1;
		end
	end

	// Result and table update.
	always_comb begin
		we   = 1'b0;
		wa   = addr;
		wk   = '0;
		wv   = '0;
		st   = ST_OK;
		vout = '0;
		if (cmd.clear) begin
			we = 1'b1;
		end else if (inv_q) begin
			st = ST_INVALID;
		end else begin
			case (func_q)
				FUNC_PUT: begin
					if (hit_q) begin
						vout = hit_val_q;
						we   = cmd.finish;
						wa   = hit_idx_q;
						wk   = key_q;
						wv   = val_q;
					end else if (free_q) begin
						we = cmd.finish;
						wa = free_idx_q;
						wk = key_q;
						wv = val_q;
					end else begin
						st = ST_FULL;
					end
				end
				FUNC_DEL: begin
					if (hit_q) begin
						we = cmd.finish;
						wa = hit_idx_q;
					end else begin
						st = ST_NOT_FOUND;
					end
				end
				default: begin
					if (hit_q) begin
						vout = hit_val_q;
					end else begin
						st = ST_NOT_FOUND;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q    <= st;
			value_out_q <= WORD_W'(vout);
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_out_q;

	`ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)
	`ASSERT_NOW(a_fail_zero_value, clk, arst_n, done_q && status_q != ST_OK, value_out_q == '0)
	`ASSERT_NOW(a_invalid_no_hit, clk, arst_n, cmd.finish && inv_q, !hit_q && !we)

endmodule
`default_nettype wire

/* hdl/key_value_slot_table_core.sv */
`default_nettype none
// A request whose key sits in slot i gives its result once the scan has reached slot i;
// a miss or a new insertion scans the whole table, and a zero key skips the scan.
// Requests: one at a time; the next is taken in the cycle the result is shown,
// and the scan reads the memories one slot per cycle.
// Reset: after arst_n rises, a clearing sweep frees every slot while busy
// is high. Results cannot be stalled by the receiver.
module key_value_slot_table_core #(
	parameter int ENTRIES     = kvst_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES   = kvst_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES = kvst_pkg::VALUE_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [kvst_pkg::FUNC_W-1:0] func,
	input  wire logic [kvst_pkg::WORD_W-1:0] key,
	input  wire logic [kvst_pkg::WORD_W-1:0] value_in,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [kvst_pkg::WORD_W-1:0]      value_out
);
	import kvst_pkg::*;

	// The controller sequences each transfer with a nonzero key through a linear
	// scan of the slot memories; the datapath holds the memories, the scan counter
	// and the match and first-free trackers. The two talk only through the
	// command and status structures below.
	cmd_t cmd;
	sts_t sts;

	kvst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath reads one slot per cycle with a registered read, so the
	// comparison of a slot lands in the cycle after its address is issued. A
	// match ends the scan early; otherwise the whole table is searched and
	// the lowest free slot remembered for an insertion.
	kvst_dp #(
		.ENTRIES     (ENTRIES),
		.KEY_BYTES   (KEY_BYTES),
		.VALUE_BYTES (VALUE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.key       (key),
		.value_in  (value_in),
		.done      (done),
		.status    (status),
		.value_out (value_out)
	);

endmodule
`default_nettype wire

/* dv/key_value_slot_table_core_tb.sv */
`default_nettype none
module key_value_slot_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kvst_pkg::*;

	// The block is built with the package defaults, so the scoreboard works at the same size.
	localparam int ENTRIES     = ENTRIES_DEF;
	localparam int KEY_BYTES   = KEY_BYTES_DEF;
	localparam int VALUE_BYTES = VALUE_BYTES_DEF;

	// Only the low bytes of a key or a value are significant. The ternary keeps the shift
	// legal when the whole word is used.
	localparam logic [WORD_W-1:0] KEY_MASK =
		(KEY_BYTES >= 8) ? '1 : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
	localparam logic [WORD_W-1:0] VALUE_MASK =
		(VALUE_BYTES >= 8) ? '1 : ((64'd1 << (8 * VALUE_BYTES)) - 64'd1);

	// The fourth function code has no name in the package. The block treats it as a lookup.
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic [WORD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

	// A full scan of the slots plus the load and result steps is the longest a request takes.
	localparam int SCAN_CYCLES     = ENTRIES + 4;
	localparam int ITEMS_PER_PHASE = 333;
	// Within a phase the first requests lean towards insertions, so that the table fills up
	// and starts to refuse new keys. The rest lean towards deletions and free slots again.
	localparam int FILL_ITEMS      = 240;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int DIRECTED_COUNT  = 20;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [WORD_W-1:0]   key;
	logic [WORD_W-1:0]   value_in;
	logic                done;
	logic [1:0]          status;
	logic [WORD_W-1:0]   value_out;

	// A reply that the table is expected to give: the status and the returned value word.
	typedef struct {
		status_t           status;
		logic [WORD_W-1:0] value;
	} table_reply_t;

	// One row of the directed stimulus. Where "typed" is set, the reply is written out in
	// the row itself. Otherwise the scoreboard works the reply out.
	typedef struct {
		logic [FUNC_W-1:0] op;
		logic [WORD_W-1:0] key_word;
		logic [WORD_W-1:0] value_word;
		bit                typed;
		status_t           want_status;
		logic [WORD_W-1:0] want_value;
	} request_row_t;

	// The scoreboard keeps its own copy of the slots. It is cleared here, just as the block
	// clears its slots after reset.
	logic [WORD_W-1:0] shadow_keys   [ENTRIES] = '{default: '0};
	logic [WORD_W-1:0] shadow_values [ENTRIES] = '{default: '0};

	table_reply_t pending_replies [$];
	int           fail_count = 0;
	int           cycle_count = 0;

	// The reply typed into a directed row travels with the request fields. The monitor picks
	// it up at the same edge as the transfer, so the two always belong together.
	bit                typed_reply;
	status_t           typed_status;
	logic [WORD_W-1:0] typed_value;

	int idle_pct [3] = '{0, 79, 25};

	request_row_t directed_rows [DIRECTED_COUNT] = '{
		// A lookup straight after reset finds nothing.
		'{FUNC_GET,   64'd1,    64'd0,       1'b1, ST_NOT_FOUND, 64'd0},
		// A zero key is refused by every function, and the table is left alone.
		'{FUNC_GET,   64'd0,    ALL_ONES,    1'b1, ST_INVALID,   64'd0},
		'{FUNC_PUT,   64'd0,    ALL_ONES,    1'b1, ST_INVALID,   64'd0},
		'{FUNC_DEL,   64'd0,    ALL_ONES,    1'b1, ST_INVALID,   64'd0},
		'{FUNC_SPARE, 64'd0,    ALL_ONES,    1'b1, ST_INVALID,   64'd0},
		// Insertion of the widest key and value, then of an empty value that reads back as zero.
		'{FUNC_PUT,   ALL_ONES, ALL_ONES,    1'b1, ST_OK,        64'd0},
		'{FUNC_PUT,   64'd1,    64'd0,       1'b1, ST_OK,        64'd0},
		'{FUNC_GET,   64'd1,    ALL_ONES,    1'b1, ST_OK,        64'd0},
		'{FUNC_GET,   ALL_ONES, 64'd0,       1'b0, ST_OK,        64'd0},
		// Replacement hands back the old value.
		'{FUNC_PUT,   ALL_ONES, 64'h0123_4567_89ab_cdef, 1'b0, ST_OK, 64'd0},
		'{FUNC_SPARE, ALL_ONES, 64'd0,       1'b0, ST_OK,        64'd0},
		// Deletion frees a slot, and a second deletion of the same key misses.
		'{FUNC_DEL,   64'd1,    ALL_ONES,    1'b1, ST_OK,        64'd0},
		'{FUNC_DEL,   64'd1,    64'd0,       1'b1, ST_NOT_FOUND, 64'd0},
		'{FUNC_GET,   64'd1,    64'd0,       1'b1, ST_NOT_FOUND, 64'd0},
		// The freed slot is the lowest one free, so the next new key lands there.
		'{FUNC_PUT,   TOP_BIT,  64'd1,       1'b1, ST_OK,        64'd0},
		'{FUNC_PUT,   64'd1,    64'd5,       1'b0, ST_OK,        64'd0},
		'{FUNC_GET,   TOP_BIT,  64'd0,       1'b0, ST_OK,        64'd0},
		'{FUNC_DEL,   ALL_ONES, 64'd0,       1'b0, ST_OK,        64'd0},
		'{FUNC_SPARE, 64'd2,    64'd0,       1'b1, ST_NOT_FOUND, 64'd0},
		'{FUNC_PUT,   TOP_BIT,  64'd0,       1'b0, ST_OK,        64'd0}
	};

	key_value_slot_table_core #(
		.ENTRIES    (ENTRIES),
		.KEY_BYTES  (KEY_BYTES),
		.VALUE_BYTES(VALUE_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.func     (func),
		.key      (key),
		.value_in (value_in),
		.done     (done),
		.status   (status),
		.value_out(value_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Serves one request against the shadow slots and returns the reply that the table
	// should give. Both scans run over the whole table: the first matching slot and the
	// lowest free slot are what the block is expected to use.
	function automatic void serve_request(input logic [FUNC_W-1:0] op,
		input logic [WORD_W-1:0] key_raw, input logic [WORD_W-1:0] value_raw,
		output status_t reply_status, output logic [WORD_W-1:0] reply_value);
		logic [WORD_W-1:0] k;
		logic [WORD_W-1:0] v;
		int hit;
		int vacant;
		int i;
		k = key_raw & KEY_MASK;
		v = value_raw & VALUE_MASK;
		reply_status = ST_OK;
		reply_value = '0;
		hit = -1;
		vacant = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && k != '0 && shadow_keys[i] == k)
				hit = i;
			if (vacant < 0 && shadow_keys[i] == '0)
				vacant = i;
		end
		if (k == '0) begin
			reply_status = ST_INVALID;
		end else if (op == FUNC_PUT) begin
			if (hit >= 0) begin
				reply_value = shadow_values[hit];
				shadow_values[hit] = v;
			end else if (vacant >= 0) begin
				shadow_keys[vacant] = k;
				shadow_values[vacant] = v;
			end else begin
				reply_status = ST_FULL;
			end
		end else if (op == FUNC_DEL) begin
			if (hit >= 0) begin
				shadow_keys[hit] = '0;
				shadow_values[hit] = '0;
			end else begin
				reply_status = ST_NOT_FOUND;
			end
		end else begin
			// A lookup, and the spare code behaves the same way.
			if (hit >= 0)
				reply_value = shadow_values[hit];
			else
				reply_status = ST_NOT_FOUND;
		end
	endfunction

	// Returns some key that is held at present, searching from a random slot onwards.
	function automatic logic [WORD_W-1:0] stored_key_from(input int first, output bit found);
		int i;
		int j;
		found = 1'b0;
		stored_key_from = '0;
		for (i = 0; i < ENTRIES; i++) begin
			j = (first + i) % ENTRIES;
			if (!found && shadow_keys[j] != '0) begin
				found = 1'b1;
				stored_key_from = shadow_keys[j];
			end
		end
	endfunction

	// A key that is most likely not held. A quarter of them are short keys of a single byte.
	// Those collide now and then, which exercises a hit on a key thought to be new.
	function automatic logic [WORD_W-1:0] fresh_key();
		if ($urandom_range(3) == 0)
			return {56'd0, 8'($urandom_range(1, 255))};
		return {$urandom, $urandom};
	endfunction

	// Builds one random request. While filling, most requests insert new keys. While draining,
	// most delete or look up keys that are held, so that hits are found all over the table.
	task automatic make_random_request(input bit filling, output logic [FUNC_W-1:0] op,
		output logic [WORD_W-1:0] k, output logic [WORD_W-1:0] v);
		int r;
		bit held;
		logic [WORD_W-1:0] known;
		r = $urandom_range(99);
		if (filling)
			op = (r < 80) ? FUNC_PUT : (r < 90) ? FUNC_GET : (r < 95) ? FUNC_DEL : FUNC_SPARE;
		else
			op = (r < 50) ? FUNC_DEL : (r < 75) ? FUNC_GET : (r < 92) ? FUNC_PUT : FUNC_SPARE;
		known = stored_key_from($urandom_range(ENTRIES - 1), held);
		r = $urandom_range(99);
		if (r < 3)
			k = '0;
		else if (!held || r < (filling ? 78 : 18))
			k = fresh_key();
		else
			k = known;
		r = $urandom_range(99);
		if (r < 10)
			v = '0;
		else if (r < 15)
			v = ALL_ONES;
		else
			v = {$urandom, $urandom};
	endtask

	// Offers one request and returns at the edge where the transfer takes place. The start
	// line is left high, so that a request that follows at once keeps it raised.
	task automatic issue(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] k,
		input logic [WORD_W-1:0] v, input bit typed, input status_t want_status,
		input logic [WORD_W-1:0] want_value);
		start <= 1'b1;
		func <= op;
		key <= k;
		value_in <= v;
		typed_reply <= typed;
		typed_status <= want_status;
		typed_value <= want_value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// The sender stays quiet for a random number of cycles. A gap often falls while the
	// block is still scanning, so start is raised at every point of its work.
	task automatic sender_pause(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Watchdog. A healthy run needs at most a scan of the table and a short gap per request,
	// which is far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Monitor and scoreboard. Everything is sampled at the rising edge, before the
	// nonblocking updates of that edge land. A result that ends in the same cycle as a new
	// transfer belongs to the previous request, so it is checked before the new reply is queued.
	always @(posedge clk) begin : scoreboard
		table_reply_t expected;
		status_t reply_status;
		logic [WORD_W-1:0] reply_value;
		if (arst_n) begin
			if (done) begin
				if (pending_replies.size() == 0) begin
					$error("result with no request outstanding: status %0d, value_out %h",
						status, value_out);
					fail_count++;
				end else begin
					expected = pending_replies.pop_front();
					if (status !== expected.status) begin
						$error("status: expected %0d, got %0d", expected.status, status);
						fail_count++;
					end
					if (value_out !== expected.value) begin
						$error("value_out: expected %h, got %h", expected.value, value_out);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				// The shadow slots are always updated. A typed row only replaces the reply.
				serve_request(func, key, value_in, reply_status, reply_value);
				if (typed_reply) begin
					reply_status = typed_status;
					reply_value = typed_value;
				end
				pending_replies.push_back('{reply_status, reply_value});
			end
		end
	end

	initial begin : stimulus
		int row;
		int phase;
		int n;
		logic [FUNC_W-1:0] op;
		logic [WORD_W-1:0] k;
		logic [WORD_W-1:0] v;

		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_GET;
		key <= '0;
		value_in <= '0;
		typed_reply <= 1'b0;
		typed_status <= ST_OK;
		typed_value <= '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		// The clearing sweep after reset keeps busy high, so the first transfer simply
		// waits for it to finish.
		for (row = 0; row < DIRECTED_COUNT; row++)
			issue(directed_rows[row].op, directed_rows[row].key_word,
				directed_rows[row].value_word, directed_rows[row].typed,
				directed_rows[row].want_status, directed_rows[row].want_value);

		// Random part in three phases: no idling, then a sender that goes on idling with a chance
		// of 79 percent at each check, then one with a chance of 25 percent. The receiver cannot
		// hold results off, so there is no stall to apply on that side.
		for (phase = 0; phase < 3; phase++) begin
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				make_random_request(n < FILL_ITEMS, op, k, v);
				issue(op, k, v, 1'b0, ST_OK, '0);
				sender_pause(idle_pct[phase]);
			end
		end
		start <= 1'b0;

		// Wait until every reply has been seen, then for one further scan, so that a stray
		// result would still be caught. The first edge lets the monitor queue the last
		// transfer before the queue is looked at.
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SCAN_CYCLES)
			@(posedge clk);

		if (pending_replies.size() != 0) begin
			$error("done: expected %0d more results, got 0", pending_replies.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
